### rtl/core/rfc_pkg.sv
`timescale 1ns / 1ps

package rfc_pkg;

    localparam int MAX_FRAME_LEN_DEF = 8191;
    localparam int MIN_FRAME_LEN     = 18;
    localparam int HEADER_LEN        = 12;
    localparam int TAIL_LEN          = 5;
    localparam int SUM_FIRST_IDX     = 6;

    localparam logic [7:0] START_CHAR_RST = 8'd126;
    localparam logic [7:0] END_CHAR_RST   = 8'd13;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_START_CHAR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CHAR   = 1'b1;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_SHORT     = 3'd1,
        ERR_BAD_START = 3'd2,
        ERR_BAD_END   = 3'd3,
        ERR_CHECKSUM  = 3'd4,
        ERR_TOO_LONG  = 3'd5
    } err_code_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [15:0]      sum;
        logic [3:0][7:0]  tail;
        logic [7:0]       first_char;
        logic [11:0][7:0] header;
    } frame_view_t;

    typedef struct packed {
        logic       frame_ok;
        err_code_t  error_code;
        logic [7:0]  dst_addr;
        logic [7:0]  src_addr;
        logic [7:0]  return_code;
        logic [7:0]  command_id;
        logic [11:0] info_length;
        logic [15:0] computed_sum;
        logic [15:0] received_sum;
    } result_t;

    // bit 4 flags a character that is not a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        begin
            case (c) inside
                [8'h30:8'h39]: d = {1'b0, c[3:0]};
                [8'h41:8'h46]: d = {1'b0, 4'(c[3:0] + 4'd9)};
                [8'h61:8'h66]: d = {1'b0, 4'(c[3:0] + 4'd9)};
                default:       d = 5'h1F;
            endcase
            return d;
        end
    endfunction

    function automatic logic [7:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
        logic [4:0] h;
        logic [4:0] l;
        logic [7:0] v;
        begin
            h = hex_digit(hi);
            l = hex_digit(lo);
            v = {(h[4] ? 4'hF : h[3:0]), l[3:0]};
            if (l[4]) begin
                v = 8'hFF;
            end
            return v;
        end
    endfunction

endpackage

### rtl/core/response_frame_checker_core.sv
`timescale 1ns / 1ps
// result: a final word passes the input register, then its result goes to the result
// register; the final word stalls while a result is untaken; other words give no result
// throughput: one word per cycle (single-pass byte update) unless a final word stalls
// reset: synchronous active-low aresetn clears byte count, sum, delay line, opening char,
// valid flags and sets start_char to 126 and end_char to 13; header chars are not reset

module response_frame_checker_core import rfc_pkg::*; #(
    parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_data_byte,
    input  logic                  s_last_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_frame_ok,
    output logic [2:0]            m_error_code,
    output logic [7:0]            m_dst_addr,
    output logic [7:0]            m_src_addr,
    output logic [7:0]            m_return_code,
    output logic [7:0]            m_command_id,
    output logic [11:0]           m_info_length,
    output logic [15:0]           m_computed_sum,
    output logic [15:0]           m_received_sum,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_FRAME_LEN + 2);

    logic             in_valid_reg, in_valid_next;
    in_item_t         in_item_reg;
    logic             advance;
    logic [7:0]       start_char_reg, end_char_reg;
    logic [CNT_W-1:0] count;
    frame_view_t      view;
    result_t          result;

    assign advance = in_valid_reg && (!in_item_reg.last_byte || !m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            start_char_reg <= START_CHAR_RST;
            end_char_reg   <= END_CHAR_RST;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_START_CHAR: start_char_reg <= cfg_wdata;
                    CFG_END_CHAR:   end_char_reg   <= cfg_wdata;
                    default:        start_char_reg <= start_char_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= '{data_byte: s_data_byte, last_byte: s_last_byte};
        end
    end

    rfc_track #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN),
        .CNT_W         (CNT_W)
    ) u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .count   (count),
        .view    (view)
    );

    rfc_eval #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN),
        .CNT_W         (CNT_W)
    ) u_eval (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .item       (in_item_reg),
        .count      (count),
        .view       (view),
        .start_char (start_char_reg),
        .end_char   (end_char_reg),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .result     (result)
    );

    assign m_frame_ok     = result.frame_ok;
    assign m_error_code   = result.error_code;
    assign m_dst_addr     = result.dst_addr;
    assign m_src_addr     = result.src_addr;
    assign m_return_code  = result.return_code;
    assign m_command_id   = result.command_id;
    assign m_info_length  = result.info_length;
    assign m_computed_sum = result.computed_sum;
    assign m_received_sum = result.received_sum;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_item_reg.last_byte |-> !m_valid || m_ready)
        else $error("result overwritten before taken");

    a_ok_matches_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_frame_ok == (m_error_code == ERR_NONE)))
        else $error("frame_ok disagrees with error code");

    a_failed_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_frame_ok |-> m_dst_addr == 8'd0 && m_info_length == 12'd0)
        else $error("failed frame carries header fields");

    a_count_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_item_reg.last_byte |=> count == '0)
        else $error("byte count not cleared after final word");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count <= CNT_W'(MAX_FRAME_LEN + 1))
        else $error("byte count beyond saturation");
`endif

endmodule

### rtl/core/rfc_track.sv
`timescale 1ns / 1ps

module rfc_track import rfc_pkg::*; #(
    parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF,
    parameter int CNT_W         = $clog2(MAX_FRAME_LEN + 2)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  in_item_t          item,
    output logic [CNT_W-1:0]  count,
    output frame_view_t       view
);

    logic [CNT_W-1:0]         count_reg, count_next;
    logic [15:0]              sum_reg, sum_next, sum_add;
    logic [TAIL_LEN-1:0][7:0] tail_reg, tail_next;
    logic [7:0]               first_reg;
    logic [7:0]               header_reg [HEADER_LEN];

    assign sum_add = (count_reg >= CNT_W'(SUM_FIRST_IDX)) ? 16'(sum_reg + 16'(tail_reg[4]))
                                                          : sum_reg;

    always_comb begin
        count_next = count_reg;
        sum_next   = sum_reg;
        tail_next  = tail_reg;
        if (advance) begin
            if (item.last_byte) begin
                count_next = '0;
                sum_next   = '0;
                tail_next  = '0;
            end else begin
                sum_next  = sum_add;
                tail_next = {tail_reg[TAIL_LEN-2:0], item.data_byte};
                if (count_reg <= CNT_W'(MAX_FRAME_LEN)) begin
                    count_next = CNT_W'(count_reg + CNT_W'(1));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            tail_reg  <= '0;
            first_reg <= '0;
        end else begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            tail_reg  <= tail_next;
            if (advance && count_reg == '0) begin
                first_reg <= item.data_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && count_reg != '0 && count_reg <= CNT_W'(HEADER_LEN)) begin
            header_reg[4'(count_reg - CNT_W'(1))] <= item.data_byte;
        end
    end

    always_comb begin
        view.sum        = sum_add;
        view.tail       = tail_reg[3:0];
        view.first_char = first_reg;
        for (int i = 0; i < HEADER_LEN; i++) begin
            view.header[i] = header_reg[i];
        end
    end

    assign count = count_reg;

endmodule

### rtl/core/rfc_eval.sv
`timescale 1ns / 1ps

module rfc_eval import rfc_pkg::*; #(
    parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF,
    parameter int CNT_W         = $clog2(MAX_FRAME_LEN + 2)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  in_item_t         item,
    input  logic [CNT_W-1:0] count,
    input  frame_view_t      view,
    input  logic [7:0]       start_char,
    input  logic [7:0]       end_char,
    input  logic             m_ready,
    output logic             m_valid,
    output result_t          result
);

    localparam int LEN_W = CNT_W + 1;
    localparam int CMP_W = (LEN_W > 13) ? LEN_W : 13;

    logic             valid_reg, valid_next;
    result_t          result_reg, result_next;
    logic [CMP_W-1:0] len_ext, info_ext;
    logic [15:0]      comp, recv;
    logic [7:0]       info_hi;
    logic [11:0]      info_raw;
    logic             load;

    assign load     = advance && item.last_byte;
    assign len_ext  = CMP_W'(count) + CMP_W'(1);
    assign comp     = 16'(17'h10000 - 17'(view.sum));
    assign recv     = {hex_pair(view.tail[3], view.tail[2]), hex_pair(view.tail[1], view.tail[0])};
    assign info_hi  = hex_pair(view.header[8], view.header[9]);
    assign info_raw = {info_hi[3:0], hex_pair(view.header[10], view.header[11])};
    assign info_ext = CMP_W'(info_raw);

    always_comb begin
        result_next = '0;
        if (count < CNT_W'(MIN_FRAME_LEN - 1)) begin
            result_next.error_code = ERR_SHORT;
        end else if (count >= CNT_W'(MAX_FRAME_LEN)) begin
            result_next.error_code = ERR_TOO_LONG;
        end else if (view.first_char != start_char) begin
            result_next.error_code = ERR_BAD_START;
        end else if (item.data_byte != end_char) begin
            result_next.error_code = ERR_BAD_END;
        end else begin
            result_next.computed_sum = comp;
            result_next.received_sum = recv;
            if (comp != recv) begin
                result_next.error_code = ERR_CHECKSUM;
            end else begin
                result_next.error_code  = ERR_NONE;
                result_next.frame_ok    = 1'b1;
                result_next.dst_addr    = hex_pair(view.header[0], view.header[1]);
                result_next.src_addr    = hex_pair(view.header[2], view.header[3]);
                result_next.return_code = hex_pair(view.header[4], view.header[5]);
                result_next.command_id  = hex_pair(view.header[6], view.header[7]);
                if (CMP_W'(info_ext + CMP_W'(MIN_FRAME_LEN)) > len_ext) begin
                    result_next.info_length = 12'(len_ext - CMP_W'(MIN_FRAME_LEN));
                end else begin
                    result_next.info_length = info_raw;
                end
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_next;
        end
    end

    assign m_valid = valid_reg;
    assign result  = result_reg;

endmodule
